/* rtl/sbmq_pkg.sv */
// sbmq_pkg: shared types and codes for the shared-buffer multi-queue.
// Holds command/status codes, the classified operation type and the
// front-to-back transfer record. No dependencies.
package sbmq_pkg;

	localparam int CMD_W    = 2;
	localparam int QID_W    = 2;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	// Command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Data returned for an empty queue and for enqueue
	localparam logic signed [DATA_W-1:0] DATA_EMPTY = -32'sd1;
	localparam logic signed [DATA_W-1:0] DATA_NONE  = 32'sd0;

	// Operation after classification by the front end
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ENQUEUE,
		OP_DEQUEUE,
		OP_PEEK,
		OP_REJECT_FULL,
		OP_REJECT_EMPTY
	} op_t;

	// Record handed from front end to back end
	typedef struct packed {
		op_t                      op;
		logic [QID_W-1:0]         qid;
		logic signed [DATA_W-1:0] data;
	} sbmq_cmd_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_ISSUE,
		BK_EXEC
	} back_state_t;

endpackage

/* rtl/sbmq_front.sv */
// sbmq_front: input stage of the shared-buffer multi-queue.
// Accepts commands, checks the queue number and registers the classified
// operation for the command queue. Depends on sbmq_pkg.
module sbmq_front #(
	parameter int NUM_QUEUES = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sbmq_pkg::CMD_W-1:0]         command,
	input  logic [sbmq_pkg::QID_W-1:0]         queue_id,
	input  logic signed [sbmq_pkg::DATA_W-1:0] data_in,
	output logic                               push_valid,
	output sbmq_pkg::sbmq_cmd_t                push_cmd,
	input  logic                               push_full
);

	logic                valid_s1;
	sbmq_pkg::sbmq_cmd_t cmd_s1;
	sbmq_pkg::op_t       op_c;
	logic                in_range;
	logic                take;

	// Classify: an out-of-range queue behaves as full and always empty
	always_comb begin
		in_range = (32'(queue_id) < NUM_QUEUES);
		case (command)
			sbmq_pkg::CMD_ENQUEUE: begin
				op_c = in_range ? sbmq_pkg::OP_ENQUEUE : sbmq_pkg::OP_REJECT_FULL;
			end
			sbmq_pkg::CMD_DEQUEUE: begin
				op_c = in_range ? sbmq_pkg::OP_DEQUEUE : sbmq_pkg::OP_REJECT_EMPTY;
			end
			sbmq_pkg::CMD_PEEK: begin
				op_c = in_range ? sbmq_pkg::OP_PEEK : sbmq_pkg::OP_REJECT_EMPTY;
			end
			default: begin
				op_c = sbmq_pkg::OP_NOP;
			end
		endcase
	end

	// Hold the stage while the command queue is full
	assign in_stall   = valid_s1 && push_full;
	assign take       = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op   <= op_c;
			cmd_s1.qid  <= queue_id;
			cmd_s1.data <= data_in;
		end
	end

endmodule

/* rtl/sbmq_cmd_fifo.sv */
// sbmq_cmd_fifo: two-entry queue between front end and back end.
// Lets either side stall on its own. Depends on sbmq_pkg.
module sbmq_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  sbmq_pkg::sbmq_cmd_t push_cmd,
	output logic                push_full,
	input  logic                pop,
	output logic                pop_valid,
	output sbmq_pkg::sbmq_cmd_t pop_cmd
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbmq_pkg::sbmq_cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_full = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop && pop_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/sbmq_back.sv */
// sbmq_back: execution engine of the shared-buffer multi-queue.
// Owns the slot data and link memories, queue pointers, free list and
// the result register. Depends on sbmq_pkg.
module sbmq_back #(
	parameter int NUM_SLOTS  = 16,
	parameter int NUM_QUEUES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	input  sbmq_pkg::sbmq_cmd_t                 pop_cmd,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sbmq_pkg::DATA_W-1:0]  data_out,
	output logic [sbmq_pkg::STATUS_W-1:0]       status
);

	localparam int SW      = $clog2(NUM_SLOTS);
	localparam int PW      = $clog2(NUM_SLOTS + 1);
	localparam int QID_MAX = 2 ** sbmq_pkg::QID_W;
	localparam int NQ      = (NUM_QUEUES < QID_MAX) ? NUM_QUEUES : QID_MAX;
	localparam int QW      = (NQ > 1) ? $clog2(NQ) : 1;
	localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

	// Memories
	logic signed [sbmq_pkg::DATA_W-1:0] slot_data [NUM_SLOTS];
	logic [PW-1:0]                      slot_link [NUM_SLOTS];

	// Pointer state
	logic [PW-1:0] head_q [NQ];
	logic [PW-1:0] tail_q [NQ];
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] fill_q;

	// Sequencer
	sbmq_pkg::back_state_t state_q;
	sbmq_pkg::back_state_t state_d;
	logic                  exec_done;
	logic                  out_free;

	// Issued command and registered read data
	sbmq_pkg::sbmq_cmd_t                cmd_q;
	logic signed [sbmq_pkg::DATA_W-1:0] data_rd_q;
	logic [PW-1:0]                      link_rd_q;
	logic                               fresh_q;
	logic [PW-1:0]                      inc_q;

	// Issue-side signals
	logic [QW-1:0] qi_in;
	logic [PW-1:0] head_in;
	logic [PW-1:0] link_addr_in;
	logic          rd_data_en;
	logic          rd_link_en;

	// Execute-side signals
	logic [QW-1:0]                      qi;
	logic [PW-1:0]                      head_cur;
	logic [PW-1:0]                      tail_cur;
	logic [PW-1:0]                      next_link;
	logic signed [sbmq_pkg::DATA_W-1:0] res_data;
	logic [sbmq_pkg::STATUS_W-1:0]      res_status;
	logic                               head_we;
	logic [PW-1:0]                      head_val;
	logic                               tail_we;
	logic                               free_we;
	logic [PW-1:0]                      free_val;
	logic                               fill_inc;
	logic                               link_we;
	logic [PW-1:0]                      link_wr_addr;
	logic [PW-1:0]                      link_wr_val;
	logic                               data_we;

	// Result register
	logic                               out_valid_q;
	logic signed [sbmq_pkg::DATA_W-1:0] data_out_q;
	logic [sbmq_pkg::STATUS_W-1:0]      status_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbmq_pkg::BK_ISSUE: begin
				if (pop_valid) begin
					state_d = sbmq_pkg::BK_EXEC;
				end
			end
			sbmq_pkg::BK_EXEC: begin
				if (out_free) begin
					state_d = sbmq_pkg::BK_ISSUE;
				end
			end
			default: begin
				state_d = sbmq_pkg::BK_ISSUE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pop       = 1'b0;
		exec_done = 1'b0;
		unique case (state_q)
			sbmq_pkg::BK_ISSUE: begin
				pop = pop_valid;
			end
			sbmq_pkg::BK_EXEC: begin
				exec_done = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbmq_pkg::BK_ISSUE;
		end else begin
			state_q <= state_d;
		end
	end

	// Issue: pick read addresses from the current pointers
	always_comb begin
		qi_in        = pop_cmd.qid[QW-1:0];
		head_in      = head_q[qi_in];
		link_addr_in = (pop_cmd.op == sbmq_pkg::OP_ENQUEUE) ? free_head_q : head_in;
		rd_data_en   = pop && (head_in != NULL_PTR) &&
			((pop_cmd.op == sbmq_pkg::OP_DEQUEUE) || (pop_cmd.op == sbmq_pkg::OP_PEEK));
		rd_link_en   = pop && (link_addr_in != NULL_PTR) &&
			((pop_cmd.op == sbmq_pkg::OP_ENQUEUE) || (pop_cmd.op == sbmq_pkg::OP_DEQUEUE));
	end

	// Latch the command; slots at or above the fill mark still link to the next slot
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= pop_cmd;
			fresh_q <= (link_addr_in >= fill_q);
			inc_q   <= link_addr_in + PW'(1);
		end
	end

	// Data memory: registered read, one write
	always_ff @(posedge clk) begin
		if (rd_data_en) begin
			data_rd_q <= slot_data[head_in[SW-1:0]];
		end
		if (data_we) begin
			slot_data[free_head_q[SW-1:0]] <= cmd_q.data;
		end
	end

	// Link memory: registered read, one write
	always_ff @(posedge clk) begin
		if (rd_link_en) begin
			link_rd_q <= slot_link[link_addr_in[SW-1:0]];
		end
		if (link_we) begin
			slot_link[link_wr_addr[SW-1:0]] <= link_wr_val;
		end
	end

	// Execute: result and pointer updates for the issued command
	always_comb begin
		qi           = cmd_q.qid[QW-1:0];
		head_cur     = head_q[qi];
		tail_cur     = tail_q[qi];
		next_link    = fresh_q ? inc_q : link_rd_q;
		res_data     = sbmq_pkg::DATA_NONE;
		res_status   = sbmq_pkg::STATUS_OK;
		head_we      = 1'b0;
		head_val     = next_link;
		tail_we      = 1'b0;
		free_we      = 1'b0;
		free_val     = next_link;
		fill_inc     = 1'b0;
		link_we      = 1'b0;
		link_wr_addr = tail_cur;
		link_wr_val  = free_head_q;
		data_we      = 1'b0;
		unique case (cmd_q.op)
			sbmq_pkg::OP_ENQUEUE: begin
				if (free_head_q == NULL_PTR) begin
					res_status = sbmq_pkg::STATUS_FULL;
				end else begin
					// take the free head, append after the tail
					free_we      = exec_done;
					fill_inc     = exec_done && fresh_q;
					head_we      = exec_done && (head_cur == NULL_PTR);
					head_val     = free_head_q;
					link_we      = exec_done && (head_cur != NULL_PTR);
					link_wr_addr = tail_cur;
					link_wr_val  = free_head_q;
					tail_we      = exec_done;
					data_we      = exec_done;
				end
			end
			sbmq_pkg::OP_DEQUEUE: begin
				if (head_cur == NULL_PTR) begin
					res_data   = sbmq_pkg::DATA_EMPTY;
					res_status = sbmq_pkg::STATUS_EMPTY;
				end else begin
					// unlink the head; a lone element leaves the queue empty
					res_data     = data_rd_q;
					head_we      = exec_done;
					head_val     = (head_cur == tail_cur) ? NULL_PTR : next_link;
					link_we      = exec_done;
					link_wr_addr = head_cur;
					link_wr_val  = free_head_q;
					free_we      = exec_done;
					free_val     = head_cur;
				end
			end
			sbmq_pkg::OP_PEEK: begin
				if (head_cur == NULL_PTR) begin
					res_data   = sbmq_pkg::DATA_EMPTY;
					res_status = sbmq_pkg::STATUS_EMPTY;
				end else begin
					res_data = data_rd_q;
				end
			end
			sbmq_pkg::OP_REJECT_FULL: begin
				res_status = sbmq_pkg::STATUS_FULL;
			end
			sbmq_pkg::OP_REJECT_EMPTY: begin
				res_data   = sbmq_pkg::DATA_EMPTY;
				res_status = sbmq_pkg::STATUS_EMPTY;
			end
			default: begin
				res_status = sbmq_pkg::STATUS_OK;
			end
		endcase
	end

	// Commit pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= NULL_PTR;
				tail_q[i] <= NULL_PTR;
			end
			free_head_q <= '0;
			fill_q      <= '0;
		end else begin
			if (head_we) begin
				head_q[qi] <= head_val;
			end
			if (tail_we) begin
				tail_q[qi] <= free_head_q;
			end
			if (free_we) begin
				free_head_q <= free_val;
			end
			if (fill_inc) begin
				fill_q <= fill_q + PW'(1);
			end
		end
	end

	// Result register: load on completion, drop when transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			data_out_q <= res_data;
			status_q   <= res_status;
		end
	end

endmodule

/* rtl/shared_buffer_multi_queue.sv */
// Shared-buffer multi-queue: NUM_QUEUES FIFOs as linked lists in one slot store.
// A command passes the front-end register, command queue, back-end issue and execute
// states and result register. The back end pops a new command only after the last has
// executed: a registered link and data memory read, then the pointer and link update.
// Reset: asynchronous, active low; queues empty, free list starts at slot 0. Untouched
// slots are tracked by a fill mark, so no clearing pass is needed.
module shared_buffer_multi_queue #(
	parameter int NUM_SLOTS  = 16,
	parameter int NUM_QUEUES = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sbmq_pkg::CMD_W-1:0]         command,
	input  logic [sbmq_pkg::QID_W-1:0]         queue_id,
	input  logic signed [sbmq_pkg::DATA_W-1:0] data_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [sbmq_pkg::DATA_W-1:0] data_out,
	output logic [sbmq_pkg::STATUS_W-1:0]      status
);

	logic                push_valid;
	sbmq_pkg::sbmq_cmd_t push_cmd;
	logic                push_full;
	logic                pop;
	logic                pop_valid;
	sbmq_pkg::sbmq_cmd_t pop_cmd;

	sbmq_front #(
		.NUM_QUEUES (NUM_QUEUES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.queue_id   (queue_id),
		.data_in    (data_in),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_full  (push_full)
	);

	sbmq_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_full  (push_full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd)
	);

	sbmq_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.status     (status)
	);

endmodule

/* rtl/sbmq_checker.sv */
// sbmq_checker.sv: port-level assertions for the shared-buffer multi-queue, and
// the bind that attaches them to the top level. Depends on sbmq_pkg.
module sbmq_port_checks (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [sbmq_pkg::CMD_W-1:0]         command,
	input logic [sbmq_pkg::QID_W-1:0]         queue_id,
	input logic signed [sbmq_pkg::DATA_W-1:0] data_in,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [sbmq_pkg::DATA_W-1:0] data_out,
	input logic [sbmq_pkg::STATUS_W-1:0]      status
);

	// A stalled command holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(command) && $stable(queue_id) &&
			$stable(data_in))
		else $error("stalled command changed");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(status))
		else $error("stalled result changed");

	// A full report carries zero data
	a_full_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sbmq_pkg::STATUS_FULL) |-> data_out == sbmq_pkg::DATA_NONE)
		else $error("full status with nonzero data");

	// An empty report carries all ones
	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sbmq_pkg::STATUS_EMPTY) |-> data_out == sbmq_pkg::DATA_EMPTY)
		else $error("empty status without all-ones data");

	// Status never shows the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == sbmq_pkg::STATUS_OK) || (status == sbmq_pkg::STATUS_FULL) ||
			(status == sbmq_pkg::STATUS_EMPTY))
		else $error("undefined status code");

endmodule

bind shared_buffer_multi_queue sbmq_port_checks u_sbmq_port_checks (.*);

/* verif/sbmq_checker.sv */
`timescale 1ns / 100ps
// sbmq_checker: watches both channels of shared_buffer_multi_queue, predicts each result
// from its own copy of the queues and free list, and counts mismatches.
// Depends on sbmq_pkg for field widths and command/status codes.
module sbmq_checker #(
	parameter int NUM_SLOTS  = 16,
	parameter int NUM_QUEUES = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [sbmq_pkg::CMD_W-1:0]         command,
	input  logic [sbmq_pkg::QID_W-1:0]         queue_id,
	input  logic signed [sbmq_pkg::DATA_W-1:0] data_in,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [sbmq_pkg::DATA_W-1:0] data_out,
	input  logic [sbmq_pkg::STATUS_W-1:0]      status,
	output int                                 pending,
	output int                                 fail_count
);

	localparam int PTR_W = $clog2(NUM_SLOTS + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

	typedef struct packed {
		logic signed [sbmq_pkg::DATA_W-1:0] data;
		logic [sbmq_pkg::STATUS_W-1:0]      status;
	} queue_result_t;

	// Shadow copy of the slot store and pointers
	logic signed [sbmq_pkg::DATA_W-1:0] slot_value [NUM_SLOTS];
	logic [PTR_W-1:0]                   next_slot  [NUM_SLOTS];
	logic [PTR_W-1:0]                   head_of    [NUM_QUEUES];
	logic [PTR_W-1:0]                   tail_of    [NUM_QUEUES];
	logic [PTR_W-1:0]                   free_top;

	queue_result_t expected_results [$];
	queue_result_t want;
	queue_result_t got;
	logic [PTR_W-1:0] slot;
	int mismatches;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// chain every slot into the free list, all queues empty
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_value[i] = '0;
				next_slot[i]  = PTR_W'(i + 1);
			end
			next_slot[NUM_SLOTS-1] = NIL;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_of[i] = NIL;
				tail_of[i] = NIL;
			end
			free_top = '0;
			expected_results.delete();
			mismatches = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			// compare an output transfer with the oldest prediction
			if (out_valid && !out_stall) begin
				got.data   = data_out;
				got.status = status;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result data_out %0d status %0d",
						$time, got.data, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got.data !== want.data) begin
						mismatches++;
						$display("%0t: data_out mismatch expected %0d actual %0d",
							$time, want.data, got.data);
					end
					if (got.status !== want.status) begin
						mismatches++;
						$display("%0t: status mismatch expected %0d actual %0d",
							$time, want.status, got.status);
					end
				end
			end

			// predict the result of an input transfer
			if (in_valid && !in_stall) begin
				want.data   = sbmq_pkg::DATA_NONE;
				want.status = sbmq_pkg::STATUS_OK;
				case (command)
					sbmq_pkg::CMD_ENQUEUE: begin
						if (int'(queue_id) >= NUM_QUEUES || free_top >= NIL) begin
							want.status = sbmq_pkg::STATUS_FULL;
						end else begin
							slot     = free_top;
							free_top = next_slot[slot];
							if (head_of[queue_id] >= NIL)
								head_of[queue_id] = slot;
							else
								next_slot[tail_of[queue_id]] = slot;
							next_slot[slot]   = NIL;
							tail_of[queue_id] = slot;
							slot_value[slot]  = data_in;
						end
					end
					sbmq_pkg::CMD_DEQUEUE, sbmq_pkg::CMD_PEEK: begin
						if (int'(queue_id) >= NUM_QUEUES || head_of[queue_id] >= NIL) begin
							want.data   = sbmq_pkg::DATA_EMPTY;
							want.status = sbmq_pkg::STATUS_EMPTY;
						end else begin
							slot      = head_of[queue_id];
							want.data = slot_value[slot];
							// unlink the head and push it onto the free list
							if (command == sbmq_pkg::CMD_DEQUEUE) begin
								head_of[queue_id] = next_slot[slot];
								next_slot[slot]   = free_top;
								free_top          = slot;
							end
						end
					end
					default: ;
				endcase
				expected_results.push_back(want);
			end

			pending    <= expected_results.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* verif/tb_shared_buffer_multi_queue.sv */
`timescale 1ns / 100ps
// tb_shared_buffer_multi_queue: clock, reset and command stimulus for the shared-buffer
// multi-queue, with random idling on both channels. Depends on sbmq_pkg and sbmq_checker.
module tb_shared_buffer_multi_queue;

	localparam int NUM_SLOTS   = 16;
	localparam int NUM_QUEUES  = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int RANDOM_CMDS = 800;
	localparam int CALM_START  = 560;
	localparam logic [sbmq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic [sbmq_pkg::CMD_W-1:0]         command   = '0;
	logic [sbmq_pkg::QID_W-1:0]         queue_id  = '0;
	logic signed [sbmq_pkg::DATA_W-1:0] data_in   = '0;
	logic                               out_stall = 1'b0;
	logic                               in_stall;
	logic                               out_valid;
	logic signed [sbmq_pkg::DATA_W-1:0] data_out;
	logic [sbmq_pkg::STATUS_W-1:0]      status;
	int                                 pending;
	int                                 fail_count;

	// idling controls; hold_done is set by the receiver when its long hold ends
	logic send_gaps = 1'b0;
	logic recv_gaps = 1'b0;
	logic hold_go   = 1'b0;
	logic hold_done = 1'b0;

	shared_buffer_multi_queue #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.queue_id  (queue_id),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.status    (status)
	);

	sbmq_checker #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.queue_id   (queue_id),
		.data_in    (data_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.status     (status),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// end the run if it hangs
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// offer one command and hold it until the transfer, then maybe idle
	task automatic send_cmd(input logic [sbmq_pkg::CMD_W-1:0] c,
			input logic [sbmq_pkg::QID_W-1:0] q, input logic [sbmq_pkg::DATA_W-1:0] d);
		command  <= c;
		queue_id <= q;
		data_in  <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// drop valid and wait until every predicted result has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int mode;
		int pick;
		logic [sbmq_pkg::QID_W-1:0]  focus_q;
		logic [sbmq_pkg::CMD_W-1:0]  c;
		logic [sbmq_pkg::QID_W-1:0]  q;
		logic [sbmq_pkg::DATA_W-1:0] d;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gaps <= 1'b1;
		recv_gaps <= 1'b1;

		// directed: empty queues, unused code, data extremes
		send_cmd(sbmq_pkg::CMD_PEEK, 2'd0, 32'h1234_5678);
		send_cmd(sbmq_pkg::CMD_DEQUEUE, 2'd3, 32'h0);
		send_cmd(CMD_UNUSED, 2'd1, 32'hFFFF_FFFF);
		send_cmd(sbmq_pkg::CMD_ENQUEUE, 2'd0, 32'h8000_0000);
		send_cmd(sbmq_pkg::CMD_ENQUEUE, 2'd1, 32'h7FFF_FFFF);
		send_cmd(sbmq_pkg::CMD_ENQUEUE, 2'd2, 32'h0000_0000);
		send_cmd(sbmq_pkg::CMD_ENQUEUE, 2'd3, 32'hFFFF_FFFF);
		send_cmd(sbmq_pkg::CMD_PEEK, 2'd0, 32'h0);
		send_cmd(sbmq_pkg::CMD_PEEK, 2'd1, 32'h0);
		send_cmd(sbmq_pkg::CMD_DEQUEUE, 2'd2, 32'h0);
		send_cmd(sbmq_pkg::CMD_DEQUEUE, 2'd2, 32'h0);
		// fill the store, then hit full and free one slot
		for (int i = 0; i < NUM_SLOTS - 3; i++)
			send_cmd(sbmq_pkg::CMD_ENQUEUE, 2'(i), sbmq_pkg::DATA_W'(i * 32'h0101_0101));
		send_cmd(sbmq_pkg::CMD_ENQUEUE, 2'd1, 32'h5555_AAAA);
		send_cmd(sbmq_pkg::CMD_DEQUEUE, 2'd0, 32'h0);

		// sender pause until everything has come back
		wait_drained();

		// random: chunks biased toward filling, draining or a mix
		mode    = 0;
		focus_q = '0;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 32 == 0) begin
				mode    = $urandom_range(0, 2);
				focus_q = sbmq_pkg::QID_W'($urandom_range(0, NUM_QUEUES - 1));
			end
			if (n == 200)
				hold_go <= 1'b1;
			if (n == 400)
				wait_drained();
			if (n == CALM_START) begin
				send_gaps <= 1'b0;
				recv_gaps <= 1'b0;
			end

			pick = $urandom_range(0, 99);
			if (pick < 3)
				c = CMD_UNUSED;
			else if (pick < (mode == 0 ? 75 : (mode == 1 ? 25 : 45)))
				c = sbmq_pkg::CMD_ENQUEUE;
			else if (pick < (mode == 0 ? 90 : 80))
				c = sbmq_pkg::CMD_DEQUEUE;
			else
				c = sbmq_pkg::CMD_PEEK;

			q = ($urandom_range(0, 1) == 0) ? focus_q :
				sbmq_pkg::QID_W'($urandom_range(0, 3));

			case ($urandom_range(0, 15))
				0:       d = 32'h8000_0000;
				1:       d = 32'h7FFF_FFFF;
				2:       d = 32'hFFFF_FFFF;
				3:       d = 32'h0000_0000;
				default: d = $urandom;
			endcase

			send_cmd(c, q, d);
		end

		// drain and let the pipeline settle
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
